>>> hw/rtl/ssoa_pkg.sv
`default_nettype none

package ssoa_pkg;

    // Motion command codes on the result channel
    typedef enum logic [1:0] {
        CMD_FORWARD = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_LEFT    = 2'd2,
        CMD_RIGHT   = 2'd3
    } cmd_t;

    // Configuration register map
    localparam int REG_INDEX_BITS = 2;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_SCAN_LENGTH = 2'd0,
        REG_NEAR_LIMIT  = 2'd1,
        REG_FAR_LIMIT   = 2'd2
    } reg_index_t;

    // Reset values of the configuration registers
    localparam int SCAN_LENGTH_DEFAULT = 360;
    localparam int NEAR_LIMIT_DEFAULT  = 384;
    localparam int FAR_LIMIT_DEFAULT   = 7680;

endpackage

`default_nettype wire

>>> hw/rtl/scan_sector_obstacle_avoider_unit.sv
`default_nettype none

// Scan-sector obstacle avoider. Range samples of a laser scan arrive one per
// transfer; the scan is split into four equal sectors of scan_length/4 samples
// and a running minimum is kept for each (later samples are ignored). On the
// sample marked scan_end the minima are clamped to the far limit and at most one
// motion command is issued, together with the four clamped minima; no command
// comes when neither sector two nor sector three reads below the near limit but
// one equals it exactly, or when sectors one and four tie while turning. The
// block takes one sample per clock while in_stall is low: a sample passes an
// input register, where its sector is decoded, and is then folded into the
// minima and decided on; a command goes to the result register. Only a last
// sample waits on a stalled result register; other samples keep flowing. Write
// the configuration registers only while no scan is in progress.
module scan_sector_obstacle_avoider_unit #(
    parameter int RANGE_BITS = 16,
    parameter int INDEX_BITS = 12,
    localparam int DATA_BITS = (RANGE_BITS > INDEX_BITS) ? RANGE_BITS : INDEX_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // configuration write port
    input  wire logic                               wr_en,
    input  wire logic [ssoa_pkg::REG_INDEX_BITS-1:0] wr_index,
    input  wire logic [DATA_BITS-1:0]               wr_data,

    // sample channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [RANGE_BITS-1:0]              range_sample,
    input  wire logic                               scan_end,

    // command channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              command,
    output logic [RANGE_BITS-1:0]                   sector_one_min,
    output logic [RANGE_BITS-1:0]                   sector_two_min,
    output logic [RANGE_BITS-1:0]                   sector_three_min,
    output logic [RANGE_BITS-1:0]                   sector_four_min
);

    localparam int LEN_BITS = INDEX_BITS - 2;

    localparam logic [INDEX_BITS-1:0] SCAN_LENGTH_RESET =
        INDEX_BITS'(ssoa_pkg::SCAN_LENGTH_DEFAULT);
    localparam logic [RANGE_BITS-1:0] NEAR_LIMIT_RESET =
        RANGE_BITS'(ssoa_pkg::NEAR_LIMIT_DEFAULT);
    localparam logic [RANGE_BITS-1:0] FAR_LIMIT_RESET =
        RANGE_BITS'(ssoa_pkg::FAR_LIMIT_DEFAULT);

    // configuration
    logic [INDEX_BITS-1:0] scan_length_reg;
    logic [RANGE_BITS-1:0] near_limit_reg;
    logic [RANGE_BITS-1:0] far_limit_reg;

    // scan state
    logic [INDEX_BITS-1:0] sample_index_reg;
    logic [INDEX_BITS-1:0] sample_index_next;
    logic [RANGE_BITS-1:0] minima_reg [4];
    logic [RANGE_BITS-1:0] minima_next [4];
    logic                  stopped_flag_reg;
    logic                  stopped_flag_next;

    // input register
    logic                  a_valid_reg;
    logic                  a_last_reg;
    logic                  a_hit_reg;
    logic [1:0]            a_sector_reg;
    logic [RANGE_BITS-1:0] a_sample_reg;

    // result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    ssoa_pkg::cmd_t        cmd_reg;
    logic [RANGE_BITS-1:0] res_min_reg [4];

    logic                  in_take;
    logic                  b_blocked;
    logic                  b_take;

    logic [LEN_BITS-1:0]   sector_len;
    logic [INDEX_BITS-1:0] bound_one;
    logic [INDEX_BITS-1:0] bound_two;
    logic [INDEX_BITS-1:0] bound_three;
    logic [INDEX_BITS-1:0] bound_four;
    logic                  sample_hit;
    logic [1:0]            sample_sector;

    logic [RANGE_BITS-1:0] folded [4];
    logic [RANGE_BITS-1:0] clamped [4];
    logic                  res_has_cmd;
    ssoa_pkg::cmd_t        res_cmd;
    logic                  set_stop;
    logic                  clear_stop;

    // Configuration writes; indexes beyond the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_length_reg <= SCAN_LENGTH_RESET;
            near_limit_reg  <= NEAR_LIMIT_RESET;
            far_limit_reg   <= FAR_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ssoa_pkg::REG_SCAN_LENGTH: scan_length_reg <= wr_data[INDEX_BITS-1:0];
                ssoa_pkg::REG_NEAR_LIMIT:  near_limit_reg  <= wr_data[RANGE_BITS-1:0];
                ssoa_pkg::REG_FAR_LIMIT:   far_limit_reg   <= wr_data[RANGE_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    // Handshake: only a last sample needs the result register free
    assign b_blocked = a_last_reg && out_valid_reg && out_stall;
    assign b_take    = a_valid_reg && !b_blocked;
    assign in_stall  = a_valid_reg && b_blocked;
    assign in_take   = in_valid && !in_stall;

    // Sector boundaries at one, two, three and four sector lengths
    assign sector_len  = scan_length_reg[INDEX_BITS-1:2];
    assign bound_one   = {2'b00, sector_len};
    assign bound_two   = {1'b0, sector_len, 1'b0};
    assign bound_four  = {sector_len, 2'b00};
    assign bound_three = bound_one + bound_two;

    // Decode the sector of the incoming sample
    always_comb
    begin
        sample_hit = (sector_len != '0) && (sample_index_reg < bound_four);
        priority if (sample_index_reg < bound_one)
            sample_sector = 2'd0;
        else if (sample_index_reg < bound_two)
            sample_sector = 2'd1;
        else if (sample_index_reg < bound_three)
            sample_sector = 2'd2;
        else
            sample_sector = 2'd3;
    end

    // Advance the sample index, saturating; restart on the last sample
    always_comb
    begin
        sample_index_next = sample_index_reg;
        if (in_take)
        begin
            if (scan_end)
                sample_index_next = '0;
            else if (sample_index_reg != '1)
                sample_index_next = sample_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            a_valid_reg      <= 1'b0;
            a_last_reg       <= 1'b0;
        end
        else
        begin
            sample_index_reg <= sample_index_next;
            if (!in_stall)
            begin
                a_valid_reg <= in_valid;
                a_last_reg  <= in_valid && scan_end;
            end
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_hit_reg    <= sample_hit;
            a_sector_reg <= sample_sector;
            a_sample_reg <= range_sample;
        end
    end

    // Fold the held sample into its sector minimum and clamp
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (a_hit_reg && (a_sector_reg == 2'(k)) && (a_sample_reg < minima_reg[k]))
                folded[k] = a_sample_reg;
            else
                folded[k] = minima_reg[k];
            clamped[k] = (folded[k] < far_limit_reg) ? folded[k] : far_limit_reg;
        end
    end

    // Decide the motion command from the clamped minima
    always_comb
    begin
        res_has_cmd = 1'b0;
        res_cmd     = ssoa_pkg::CMD_FORWARD;
        set_stop    = 1'b0;
        clear_stop  = 1'b0;
        priority if ((clamped[1] > near_limit_reg) && (clamped[2] > near_limit_reg))
        begin
            res_has_cmd = 1'b1;
            res_cmd     = ssoa_pkg::CMD_FORWARD;
            clear_stop  = 1'b1;
        end
        else if ((clamped[1] < near_limit_reg) || (clamped[2] < near_limit_reg))
        begin
            priority if (!stopped_flag_reg)
            begin
                res_has_cmd = 1'b1;
                res_cmd     = ssoa_pkg::CMD_STOP;
                set_stop    = 1'b1;
            end
            else if ((clamped[0] > clamped[1]) && (clamped[0] > clamped[2]))
            begin
                res_has_cmd = 1'b1;
                res_cmd     = ssoa_pkg::CMD_LEFT;
            end
            else if ((clamped[3] > clamped[1]) && (clamped[3] > clamped[2]))
            begin
                res_has_cmd = 1'b1;
                res_cmd     = ssoa_pkg::CMD_RIGHT;
            end
            else if (clamped[0] > clamped[3])
            begin
                res_has_cmd = 1'b1;
                res_cmd     = ssoa_pkg::CMD_LEFT;
            end
            else if (clamped[0] < clamped[3])
            begin
                res_has_cmd = 1'b1;
                res_cmd     = ssoa_pkg::CMD_RIGHT;
            end
            else
            begin
                res_has_cmd = 1'b0;
            end
        end
        else
        begin
            res_has_cmd = 1'b0;
        end
    end

    // Next scan state: keep folded minima, clear them at the end of a scan
    always_comb
    begin
        stopped_flag_next = stopped_flag_reg;
        for (int k = 0; k < 4; k++)
            minima_next[k] = minima_reg[k];
        if (b_take)
        begin
            for (int k = 0; k < 4; k++)
                minima_next[k] = a_last_reg ? '1 : folded[k];
            if (a_last_reg && set_stop)
                stopped_flag_next = 1'b1;
            else if (a_last_reg && clear_stop)
                stopped_flag_next = 1'b0;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (b_take && a_last_reg && res_has_cmd)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                minima_reg[k] <= '1;
            stopped_flag_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                minima_reg[k] <= minima_next[k];
            stopped_flag_reg <= stopped_flag_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload, loaded only with a fresh command
    always_ff @(posedge clk)
    begin
        if (b_take && a_last_reg && res_has_cmd)
        begin
            cmd_reg <= res_cmd;
            for (int k = 0; k < 4; k++)
                res_min_reg[k] <= clamped[k];
        end
    end

    assign out_valid        = out_valid_reg;
    assign command          = cmd_reg;
    assign sector_one_min   = res_min_reg[0];
    assign sector_two_min   = res_min_reg[1];
    assign sector_three_min = res_min_reg[2];
    assign sector_four_min  = res_min_reg[3];

    // Only a held last sample may hold up the sample channel
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && a_last_reg && out_valid_reg))
        else $error("sample channel stalled without a pending last sample");

    // The sample index restarts after a last sample
    a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && scan_end) |=> (sample_index_reg == '0))
        else $error("sample index not cleared at end of scan");

    // Sector minima return to all ones once a scan is decided
    a_minima_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (b_take && a_last_reg) |=> ((minima_reg[0] == '1) && (minima_reg[1] == '1)
                                    && (minima_reg[2] == '1) && (minima_reg[3] == '1)))
        else $error("sector minima not cleared at end of scan");

    // A stop command leaves the stop flag set
    a_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (b_take && a_last_reg && res_has_cmd && (res_cmd == ssoa_pkg::CMD_STOP))
        |=> (stopped_flag_reg && out_valid_reg))
        else $error("stop issued without setting the stop flag");

endmodule

`default_nettype wire
